### rtl/core/tsp_pkg.sv
// Shared types and constants for the text screen page counter.
// No dependencies; used by every module under rtl/core.
package tsp_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_DISP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_DISP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GLYPH_SIZE  = 2'd2;
   localparam logic [1:0] CSR_AUTO_WRAP   = 2'd3;

   // Configuration reset values
   localparam logic [15:0] DISP_WIDTH_RST  = 16'd64;
   localparam logic [15:0] DISP_HEIGHT_RST = 16'd32;
   localparam logic [6:0]  GLYPH_SIZE_RST  = 7'd16;
   localparam logic [15:0] LINES_RST       = 16'd2;

   // Special byte values
   localparam logic [7:0] WIDE_LEAD_MIN = 8'hA0;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_LF         = 8'h0A;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Operation codes passed from the front to the back
   localparam logic [2:0] OP_HALF = 3'd0;
   localparam logic [2:0] OP_WIDE = 3'd1;
   localparam logic [2:0] OP_CR   = 3'd2;
   localparam logic [2:0] OP_LF   = 3'd3;
   localparam logic [2:0] OP_EMIT = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic [15:0] disp_width;
      logic [6:0]  glyph_size;
      logic        auto_wrap;
      logic [15:0] lines_per_screen;
   } cfg_type;

endpackage

### rtl/core/tsp_div.sv
// Lines-per-screen divider: display height / glyph size, one quotient bit per cycle.
// Depends on tsp_pkg.
module tsp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [6:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);

   logic [15:0] q_ff, q_in;
   logic [6:0]  r_ff, r_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [15:0] res_ff, res_in;
   logic [8:0]  diff;
   logic [7:0]  shifted;

   // One restoring step
   always_comb begin
      shifted = {r_ff, q_ff[15]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      res_in  = res_ff;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[8]) begin
            r_in = diff[6:0];
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = shifted[6:0];
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            res_in  = (divisor == 7'd0) ? 16'd0 : q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         res_ff  <= tsp_pkg::LINES_RST;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         res_ff  <= res_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy     = busy_ff;
   assign quotient = res_ff;

endmodule

### rtl/core/tsp_front.sv
// Front end: accepts text words, tracks trail bytes, classifies into ops.
// Depends on tsp_pkg.
module tsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   input  logic                hold,
   input  logic                enq_ready,
   output logic                enq_valid,
   output tsp_pkg::entry_type  enq_entry
);

   logic skip_ff, skip_in;
   logic accept;
   logic push;

   assign req_ready = enq_ready & ~hold;
   assign accept    = req_valid & req_ready;

   // Classify the byte
   always_comb begin
      push           = 1'b1;
      enq_entry.last = req_end_of_text;
      enq_entry.op   = tsp_pkg::OP_HALF;
      if (skip_ff) begin
         // trail byte: dropped unless it ends the text
         enq_entry.op = tsp_pkg::OP_EMIT;
         push         = req_end_of_text;
      end else if (req_text_byte == 8'd0) begin
         enq_entry.op = tsp_pkg::OP_EMIT;
      end else if (req_text_byte > tsp_pkg::WIDE_LEAD_MIN) begin
         enq_entry.op = tsp_pkg::OP_WIDE;
      end else if (req_text_byte == tsp_pkg::CH_CR) begin
         enq_entry.op = tsp_pkg::OP_CR;
      end else if (req_text_byte == tsp_pkg::CH_LF) begin
         enq_entry.op = tsp_pkg::OP_LF;
      end
   end

   assign enq_valid = accept & push;

   // Next byte is a trail after a wide lead that does not end the text
   always_comb begin
      skip_in = skip_ff;
      if (accept) begin
         skip_in = ~skip_ff & (enq_entry.op == tsp_pkg::OP_WIDE) & ~req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else begin
         skip_ff <= skip_in;
      end
   end

endmodule

### rtl/core/tsp_queue.sv
// Two-entry queue of classified ops between front and back.
// Depends on tsp_pkg.
module tsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                enq_valid,
   input  tsp_pkg::entry_type  enq_entry,
   output logic                enq_ready,
   output logic                deq_valid,
   output tsp_pkg::entry_type  deq_entry,
   input  logic                deq_ready
);

   tsp_pkg::entry_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign enq_ready = (cnt_ff != 2'd2);
   assign deq_valid = (cnt_ff != 2'd0);
   assign deq_entry = ent_ff[rd_ptr_ff];
   assign push      = enq_valid & enq_ready;
   assign pop       = deq_valid & deq_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= enq_entry;
      end
   end

endmodule

### rtl/core/tsp_back.sv
// Back end: column, line and screen tracking, and the result register.
// Depends on tsp_pkg.
module tsp_back (
   input  logic                clock,
   input  logic                reset,
   input  tsp_pkg::cfg_type    cfg,
   input  logic                deq_valid,
   input  tsp_pkg::entry_type  deq_entry,
   output logic                deq_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_screen_count
);

   logic [16:0] col_ff, col_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] screen_ff, screen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] count_ff, count_in;

   logic        emit, pop, glyph, ovf, single, adv, li_wrap;
   logic [6:0]  cw;
   logic [17:0] col_sum;
   logic [16:0] width17, wrap_col;
   logic [15:0] li_inc, screen_next, line_next;
   logic [16:0] col_next;

   assign emit      = (deq_entry.op == tsp_pkg::OP_EMIT) | deq_entry.last;
   assign deq_ready = ~emit | ~rsp_valid_ff | rsp_ready;
   assign pop       = deq_valid & deq_ready;

   // Glyph placement
   always_comb begin
      glyph   = (deq_entry.op == tsp_pkg::OP_WIDE) | (deq_entry.op == tsp_pkg::OP_HALF);
      cw      = (deq_entry.op == tsp_pkg::OP_WIDE) ? cfg.glyph_size : (cfg.glyph_size >> 1);
      width17 = {1'b0, cfg.disp_width};
      col_sum = {1'b0, col_ff} + {11'd0, cw};
      ovf     = col_sum > {2'b00, cfg.disp_width};
      single  = ~((cfg.lines_per_screen > 16'd1) | cfg.auto_wrap);
      // single-line clip leaves only what fits after the old column
      if (single) begin
         wrap_col = (width17 > col_ff) ? (width17 - col_ff) : 17'd0;
      end else begin
         wrap_col = {10'd0, cw};
      end
   end

   // Line and screen advance
   always_comb begin
      adv         = (deq_entry.op == tsp_pkg::OP_LF) | (glyph & ovf);
      li_inc      = line_ff + 16'd1;
      li_wrap     = li_inc >= cfg.lines_per_screen;
      line_next   = line_ff;
      screen_next = screen_ff;
      if (adv) begin
         line_next = li_wrap ? 16'd0 : li_inc;
         if (li_wrap && screen_ff != tsp_pkg::COUNT_MAX) begin
            screen_next = screen_ff + 16'd1;
         end
      end
   end

   always_comb begin
      case (deq_entry.op)
         tsp_pkg::OP_HALF,
         tsp_pkg::OP_WIDE: col_next = ovf ? wrap_col : col_sum[16:0];
         tsp_pkg::OP_CR,
         tsp_pkg::OP_LF:   col_next = 17'd0;
         default:          col_next = col_ff;
      endcase
   end

   // State update and result word
   always_comb begin
      col_in       = col_ff;
      line_in      = line_ff;
      screen_in    = screen_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (pop) begin
         if (emit) begin
            col_in       = '0;
            line_in      = '0;
            screen_in    = '0;
            rsp_valid_in = 1'b1;
            count_in     = (screen_next == tsp_pkg::COUNT_MAX) ? tsp_pkg::COUNT_MAX
                                                              : screen_next + 16'd1;
         end else begin
            col_in    = col_next;
            line_in   = line_next;
            screen_in = screen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         screen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         screen_ff    <= screen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_screen_count = count_ff;

endmodule

### rtl/core/text_screen_page_counter.sv
// Top level of the text screen page counter: configuration registers,
// divider, front end, queue and back end. Depends on tsp_pkg and all tsp_* modules.
//
// Counts the display screens a text fills, one text byte per word. In steady
// state one byte is accepted every cycle while the divider is idle and the op
// queue has room. The result word is registered: the op queue is written at
// the edge that accepts the byte ending the text, and the back-end result register
// when the back end takes that op, which waits while an earlier result is not taken.
// While a bit-serial divider computes lines per screen after a write of the
// display height or the glyph size, the block accepts no bytes.
module text_screen_page_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_screen_count,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] disp_width_ff, disp_height_ff;
   logic [6:0]  glyph_size_ff;
   logic        auto_wrap_ff;

   logic               div_start, div_busy;
   logic [15:0]        div_dividend, lines;
   tsp_pkg::cfg_type   cfg;
   logic               enq_valid, enq_ready, deq_valid, deq_ready;
   tsp_pkg::entry_type enq_entry, deq_entry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_width_ff  <= tsp_pkg::DISP_WIDTH_RST;
         disp_height_ff <= tsp_pkg::DISP_HEIGHT_RST;
         glyph_size_ff  <= tsp_pkg::GLYPH_SIZE_RST;
         auto_wrap_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            tsp_pkg::CSR_DISP_WIDTH:  disp_width_ff  <= csr_wdata;
            tsp_pkg::CSR_DISP_HEIGHT: disp_height_ff <= csr_wdata;
            tsp_pkg::CSR_GLYPH_SIZE:  glyph_size_ff  <= csr_wdata[6:0];
            tsp_pkg::CSR_AUTO_WRAP:   auto_wrap_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Recompute lines per screen on a height or glyph size write
   assign div_start    = csr_we & ((csr_index == tsp_pkg::CSR_DISP_HEIGHT) |
                                   (csr_index == tsp_pkg::CSR_GLYPH_SIZE));
   assign div_dividend = (csr_index == tsp_pkg::CSR_DISP_HEIGHT) ? csr_wdata : disp_height_ff;

   tsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (glyph_size_ff),
      .busy     (div_busy),
      .quotient (lines)
   );

   assign cfg.disp_width       = disp_width_ff;
   assign cfg.glyph_size       = glyph_size_ff;
   assign cfg.auto_wrap        = auto_wrap_ff;
   assign cfg.lines_per_screen = lines;

   tsp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .hold            (div_busy),
      .enq_ready       (enq_ready),
      .enq_valid       (enq_valid),
      .enq_entry       (enq_entry)
   );

   tsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry),
      .enq_ready (enq_ready),
      .deq_valid (deq_valid),
      .deq_entry (deq_entry),
      .deq_ready (deq_ready)
   );

   tsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .deq_valid        (deq_valid),
      .deq_entry        (deq_entry),
      .deq_ready        (deq_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_screen_count (rsp_screen_count)
   );

endmodule

### verif/tsp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the text screen page counter: tracks register writes, predicts
// the screen count of each text and checks every result word. Depends on tsp_pkg.
module tsp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_screen_count,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          outstanding,
   output int          results_checked
);

   // Shadow copy of the configuration
   logic [15:0] cfg_width;
   logic [15:0] cfg_height;
   logic [6:0]  cfg_font;
   logic        cfg_wrap;
   logic [15:0] lines_per_screen;

   // Layout state of the text in progress
   int unsigned column_pos;
   int unsigned line_index;
   int unsigned screen_index;
   logic        skip_trail;

   logic [15:0] expected_counts[$];

   function automatic logic [15:0] lines_for(logic [15:0] height, logic [6:0] font);
      return (font == 7'd0) ? 16'd0 : height / font;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic advance_line();
      line_index = (line_index + 1) & 32'hFFFF;
      if (line_index >= lines_per_screen) begin
         line_index = 0;
         if (screen_index < tsp_pkg::COUNT_MAX) screen_index++;
      end
   endtask

   // A glyph that overflows moves to a new line; with a single line and no
   // wrap it keeps only the part that did not overflow
   task automatic place_glyph(int unsigned glyph_w);
      int unsigned clip;
      clip = 0;
      if (column_pos + glyph_w > cfg_width) begin
         if (!(lines_per_screen > 1 || cfg_wrap)) clip = column_pos + glyph_w - cfg_width;
         advance_line();
         column_pos = 0;
      end
      if (glyph_w > clip) column_pos = (column_pos + glyph_w - clip) & 32'h1FFFF;
   endtask

   task automatic close_text();
      expected_counts.push_back((screen_index >= tsp_pkg::COUNT_MAX) ? tsp_pkg::COUNT_MAX
                                                                      : 16'(screen_index + 1));
      column_pos   = 0;
      line_index   = 0;
      screen_index = 0;
      skip_trail   = 1'b0;
   endtask

   task automatic predict_byte(logic [7:0] text_byte, logic last);
      if (skip_trail) begin
         skip_trail = 1'b0;
         if (last) close_text();
      end else if (text_byte == 8'd0) begin
         close_text();
      end else begin
         if (text_byte > tsp_pkg::WIDE_LEAD_MIN) begin
            place_glyph(32'(cfg_font));
            skip_trail = 1'b1;
         end else if (text_byte == tsp_pkg::CH_CR) begin
            column_pos = 0;
         end else if (text_byte == tsp_pkg::CH_LF) begin
            column_pos = 0;
            advance_line();
         end else begin
            place_glyph(32'(cfg_font / 2));
         end
         if (last) close_text();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_width        = tsp_pkg::DISP_WIDTH_RST;
         cfg_height       = tsp_pkg::DISP_HEIGHT_RST;
         cfg_font         = tsp_pkg::GLYPH_SIZE_RST;
         cfg_wrap         = 1'b0;
         lines_per_screen = tsp_pkg::LINES_RST;
         column_pos       = 0;
         line_index       = 0;
         screen_index     = 0;
         skip_trail       = 1'b0;
         expected_counts.delete();
      end else begin
         // register writes, masked to each register's width
         if (csr_we) begin
            case (csr_index)
               tsp_pkg::CSR_DISP_WIDTH: cfg_width = csr_wdata;
               tsp_pkg::CSR_DISP_HEIGHT: begin
                  cfg_height       = csr_wdata;
                  lines_per_screen = lines_for(cfg_height, cfg_font);
               end
               tsp_pkg::CSR_GLYPH_SIZE: begin
                  cfg_font         = csr_wdata[6:0];
                  lines_per_screen = lines_for(cfg_height, cfg_font);
               end
               tsp_pkg::CSR_AUTO_WRAP: cfg_wrap = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) predict_byte(req_text_byte, req_end_of_text);

         // each result word against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch("screen_count with no text pending", rsp_screen_count, 16'd0);
            end else begin
               if (rsp_screen_count !== expected_counts[0])
                  report_mismatch("screen_count", rsp_screen_count, expected_counts[0]);
               void'(expected_counts.pop_front());
               results_checked++;
            end
         end
      end
      outstanding = expected_counts.size();
   end

endmodule

### verif/tb_text_screen_page_counter.sv
`timescale 1ns / 1ps
// Top of the text screen page counter testbench: clock, reset, text stimulus,
// register settings and verdict. Depends on tsp_pkg, the block and tsp_checker.
module tb_text_screen_page_counter;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_mode_type;

   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_WORDS  = 135;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_text_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_screen_count;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int chk_mismatches;
   int chk_outstanding;
   int chk_results;

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_pending;
   int words_sent;
   int settings_used;

   text_screen_page_counter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_screen_count (rsp_screen_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   tsp_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_screen_count (rsp_screen_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (chk_mismatches),
      .outstanding      (chk_outstanding),
      .results_checked  (chk_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic set_idling(idling_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
         default:       begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
   endtask

   // One text byte; returns at the edge that accepts it
   task automatic send_word(logic [7:0] text_byte, logic last);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= text_byte;
      req_end_of_text <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Drop valid and let every expected word and any byte in flight drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (chk_outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_setting(logic [15:0] width, logic [15:0] height,
                                logic [15:0] font, logic [15:0] wrap);
      wait_idle();
      write_reg(tsp_pkg::CSR_DISP_WIDTH, width);
      write_reg(tsp_pkg::CSR_AUTO_WRAP, wrap);
      write_reg(tsp_pkg::CSR_DISP_HEIGHT, height);
      write_reg(tsp_pkg::CSR_GLYPH_SIZE, font);
      settings_used++;
   endtask

   // Mostly well-formed text: glyphs, wide pairs, line controls, some noise
   task automatic send_text(int len);
      int i;
      int pick;
      logic [7:0] b;
      i = 0;
      while (i < len) begin
         pick = $urandom_range(99);
         if (pick < 45)      b = 8'($urandom_range(8'h20, 8'h7E));
         else if (pick < 72) b = 8'($urandom_range(8'hA1, 8'hFF));
         else if (pick < 82) b = tsp_pkg::CH_LF;
         else if (pick < 88) b = tsp_pkg::CH_CR;
         else if (pick < 97) b = 8'($urandom_range(1, 8'hA0));
         else                b = 8'($urandom_range(0, 255));
         send_word(b, i == len - 1);
         i++;
         if (b > tsp_pkg::WIDE_LEAD_MIN && i < len) begin
            send_word(8'($urandom_range(0, 255)), i == len - 1);
            i++;
         end
      end
   endtask

   task automatic random_texts(int count);
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at)
         send_text(($urandom_range(99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 160));
   endtask

   initial begin
      int phase;
      int k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = 8'd0;
      req_end_of_text = 1'b0;
      csr_we          = 1'b0;
      csr_index       = tsp_pkg::CSR_DISP_WIDTH;
      csr_wdata       = 16'd0;
      hold_pending    = 1'b0;
      words_sent      = 0;
      settings_used   = 1;
      set_idling(IDLE_NONE);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed texts at the reset configuration (two lines of 64 pixels)
      send_word(8'h41, 1'b1);
      send_word(8'h00, 1'b0);            // zero lead without end marker
      send_word(8'h00, 1'b1);
      send_word(8'hA1, 1'b1);            // wide lead carrying the end marker
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);            // zero trail is skipped
      send_word(8'h7F, 1'b0);
      send_word(8'hA0, 1'b0);            // not a wide lead
      send_word(tsp_pkg::CH_CR, 1'b0);
      send_word(tsp_pkg::CH_LF, 1'b0);
      send_word(tsp_pkg::CH_LF, 1'b0);   // runs out of lines
      send_word(8'h01, 1'b1);
      send_word(8'hC3, 1'b0);
      send_word(8'hFF, 1'b1);            // trail carrying the end marker
      for (k = 0; k < 9; k++) send_word(8'h80, k == 8);   // overflow wraps

      // Random phases, each under its own setting and idling mode
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_setting(16'd100, 16'd48, 16'd12, 16'd0);
            1: apply_setting(16'd20, 16'd16, 16'd16, 16'd0);       // single line, clipped
            2: apply_setting(16'd20, 16'd16, 16'd16, 16'd1);
            3: apply_setting(16'd0, 16'hFFFF, 16'd1, 16'd0);
            4: apply_setting(16'hFFFF, 16'd0, 16'd64, 16'd1);      // no lines per screen
            5: apply_setting(16'd33, 16'd200, 16'd0, 16'd0);      // zero font size
            6: apply_setting(16'($urandom_range(0, 400)), 16'($urandom_range(0, 600)),
                             16'($urandom), 16'($urandom));
            default: apply_setting(16'd48, 16'd64, 16'd7, 16'hFFFE);
         endcase
         set_idling(idling_mode_type'(phase % 4));
         random_texts(PHASE_WORDS);

         if (phase == 0) begin
            // receiver holds off while one-byte texts keep coming
            hold_pending = 1'b1;
            for (k = 0; k < 40; k++) send_word(8'($urandom_range(1, 8'h9F)), 1'b1);
         end
      end

      wait_idle();
      $display("%0d text bytes over %0d register settings, %0d screen counts checked",
               words_sent, settings_used, chk_results);
      $display("covered wide pairs, line controls, clipping, zero font and zero lines");
      if (chk_mismatches == 0 && chk_outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tsp_pkg.sv
rtl/core/tsp_div.sv
rtl/core/tsp_front.sv
rtl/core/tsp_queue.sv
rtl/core/tsp_back.sv
rtl/core/text_screen_page_counter.sv
verif/tsp_checker.sv
verif/tb_text_screen_page_counter.sv
